FILE: hdl/pabl_pkg.sv
// Shared types and constants for the premultiplied ARGB overlay blend unit.
// No dependencies.
package pabl_pkg;

   localparam int CoefBits = 18;
   localparam int RowBits  = 3 * CoefBits;
   localparam int TBits    = 40;

   // twice the range scale, and (2*offset+1) for the rounding numerator
   localparam logic [9:0] LumaScaleLim  = 10'd438;
   localparam logic [9:0] LumaScaleFull = 10'd510;
   localparam logic [9:0] ChromaScaleLim  = 10'd448;
   localparam logic [9:0] ChromaScaleFull = 10'd510;
   localparam logic [8:0] LumaOffLim  = 9'd33;
   localparam logic [8:0] LumaOffFull = 9'd1;
   localparam logic [8:0] ChromaOff   = 9'd257;

   typedef enum logic [2:0] {
      CSR_COEF_LUMA = 3'd0,
      CSR_COEF_CB   = 3'd1,
      CSR_COEF_CR   = 3'd2,
      CSR_LIMITED   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic en;
      logic lim;
   } ctl_type;

   typedef struct packed {
      logic [3:0][7:0] a;
      logic [3:0][7:0] dy;
      logic [7:0]      dcb;
      logic [7:0]      dcr;
   } side_type;

endpackage

FILE: hdl/pabl_div.sv
// Pipelined saturating divider: floor(t / (131072*d)) clamped to 0..255.
// Nine restoring stages, one quotient bit each. Uses pabl_pkg.
module pabl_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [pabl_pkg::TBits-1:0] t,
   input  logic [7:0]                    d,
   output logic [7:0]                    q
);
   import pabl_pkg::*;

   localparam int RW = TBits - 1;
   localparam int NS = 9;

   logic [RW-1:0] rem_ff [NS];
   logic [8:0]    q_ff   [NS];
   logic [7:0]    d_ff   [NS];
   logic [RW-1:0] rem0;

   assign rem0 = t[TBits-1] ? '0 : t[RW-1:0];

   for (genvar j = 0; j < NS; j++) begin : g_stage
      localparam int K = NS - 1 - j;
      logic [RW-1:0] rem_prev, den, diff;
      logic [8:0]    q_prev;
      logic [7:0]    d_prev;
      logic          ge;
      if (j == 0) begin : g_first
         assign rem_prev = rem0;
         assign q_prev   = '0;
         assign d_prev   = d;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign d_prev   = d_ff[j-1];
      end
      assign den  = RW'(d_prev) << (17 + K);
      assign ge   = rem_prev >= den;
      assign diff = rem_prev - den;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? diff : rem_prev;
            q_ff[j]   <= q_prev | (9'(ge) << K);
            d_ff[j]   <= d_prev;
         end
      end
   end

   assign q = q_ff[NS-1][8] ? 8'd255 : q_ff[NS-1][7:0];

endmodule

FILE: hdl/pabl_lane.sv
// One pixel lane: matrix products, scaled numerators and three dividers.
// Uses pabl_pkg and pabl_div.
module pabl_lane (
   input  logic                              clock,
   input  pabl_pkg::ctl_type                 ctl,
   input  logic [2:0][pabl_pkg::RowBits-1:0] coef,
   input  logic [31:0]                       px,
   output logic [7:0]                        y,
   output logic [7:0]                        cb,
   output logic [7:0]                        cr
);
   import pabl_pkg::*;

   logic signed [26:0] prod_ff [3][3];
   logic [7:0]         d_p_ff, d_t_ff;
   logic signed [TBits-1:0] t_ff [3];
   logic [7:0]         d;
   logic [7:0]         q [3];

   assign d = (px[31:24] == 8'd0) ? 8'd255 : px[31:24];

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               prod_ff[r][c] <= $signed(coef[r][c*CoefBits +: CoefBits])
                              * $signed({1'b0, px[(2-c)*8 +: 8]});
         d_p_ff <= d;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [28:0] s;
      logic [9:0]         m2;
      logic [8:0]         off;
      logic [16:0]        od;
      logic signed [TBits-1:0] t_in;
      assign s = 29'(prod_ff[r][0]) + 29'(prod_ff[r][1]) + 29'(prod_ff[r][2]);
      if (r == 0) begin : g_luma
         assign m2  = ctl.lim ? LumaScaleLim : LumaScaleFull;
         assign off = ctl.lim ? LumaOffLim : LumaOffFull;
      end else begin : g_chroma
         assign m2  = ctl.lim ? ChromaScaleLim : ChromaScaleFull;
         assign off = ChromaOff;
      end
      assign od   = off * d_p_ff;
      assign t_in = s * $signed({1'b0, m2}) + $signed({7'b0, od, 16'b0});
      always_ff @(posedge clock) begin
         if (ctl.en)
            t_ff[r] <= t_in;
      end
      pabl_div u_div (
         .clock (clock),
         .en    (ctl.en),
         .t     (t_ff[r]),
         .d     (d_t_ff),
         .q     (q[r])
      );
   end

   always_ff @(posedge clock) begin
      if (ctl.en)
         d_t_ff <= d_p_ff;
   end

   assign y  = q[0];
   assign cb = q[1];
   assign cr = q[2];

endmodule

FILE: hdl/pabl_merge.sv
// Merge stage: per-pixel luma blend, chroma and alpha averaging, chroma blend.
// Two pipeline stages. Uses pabl_pkg.
module pabl_merge (
   input  logic                clock,
   input  pabl_pkg::ctl_type   ctl,
   input  logic [3:0][7:0]     y,
   input  logic [3:0][7:0]     cb,
   input  logic [3:0][7:0]     cr,
   input  pabl_pkg::side_type  side,
   output logic [3:0][7:0]     out_y,
   output logic [7:0]          out_cb,
   output logic [7:0]          out_cr
);
   import pabl_pkg::*;

   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [17:0] s;
      s = 18'(x) + 18'(x[16:8]) + 18'd1;
      return s[15:8];
   endfunction

   logic [16:0] py_ff [4];
   logic [16:0] pcb_ff, pcr_ff;
   logic [9:0]  cb_sum, cr_sum, a_sum;
   logic [7:0]  cb_m, cr_m, a_m;

   assign cb_sum = 10'(cb[0]) + 10'(cb[1]) + 10'(cb[2]) + 10'(cb[3]);
   assign cr_sum = 10'(cr[0]) + 10'(cr[1]) + 10'(cr[2]) + 10'(cr[3]);
   assign a_sum  = 10'(side.a[0]) + 10'(side.a[1]) + 10'(side.a[2]) + 10'(side.a[3]);
   assign cb_m = cb_sum[9:2];
   assign cr_m = cr_sum[9:2];
   assign a_m  = a_sum[9:2];

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         for (int i = 0; i < 4; i++)
            py_ff[i] <= 17'(side.dy[i]) * 17'(8'd255 - side.a[i])
                      + 17'(y[i]) * 17'(side.a[i]);
         pcb_ff <= 17'(side.dcb) * 17'(8'd255 - a_m) + 17'(cb_m) * 17'(a_m);
         pcr_ff <= 17'(side.dcr) * 17'(8'd255 - a_m) + 17'(cr_m) * 17'(a_m);
         for (int i = 0; i < 4; i++)
            out_y[i] <= div255(py_ff[i]);
         out_cb <= div255(pcb_ff);
         out_cr <= div255(pcr_ff);
      end
   end

endmodule

FILE: hdl/premult_argb_overlay_yuv420_blend_unit.sv
// Premultiplied ARGB overlay blend over one 2x2 YCbCr 4:2:0 block per word.
// One word per cycle when the output is not stalled, through four pixel
// lanes, each a 2-stage matrix front end and 9-stage bit-per-stage dividers,
// followed by a 2-stage merge. The whole pipeline holds while a result word waits.
// Synchronous reset clears valids and sets coefficients to 0, limited range on.
// Uses pabl_pkg, pabl_lane and pabl_merge.
module premult_argb_overlay_yuv420_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_overlay_px0,
   input  logic [31:0] req_overlay_px1,
   input  logic [31:0] req_overlay_px2,
   input  logic [31:0] req_overlay_px3,
   input  logic [7:0]  req_dest_y0,
   input  logic [7:0]  req_dest_y1,
   input  logic [7:0]  req_dest_y2,
   input  logic [7:0]  req_dest_y3,
   input  logic [7:0]  req_dest_cb,
   input  logic [7:0]  req_dest_cr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_y0,
   output logic [7:0]  rsp_out_y1,
   output logic [7:0]  rsp_out_y2,
   output logic [7:0]  rsp_out_y3,
   output logic [7:0]  rsp_out_cb,
   output logic [7:0]  rsp_out_cr,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  pabl_pkg::csr_index_type csr_index,
   input  logic [53:0] csr_data
);
   import pabl_pkg::*;

   localparam int LaneDepth = 11;
   localparam int Depth     = LaneDepth + 2;

   logic [2:0][RowBits-1:0] coef_ff;
   logic                    lim_ff;
   logic [Depth-1:0]        vld_ff;
   side_type                side_ff [LaneDepth];
   side_type                side_in;
   ctl_type                 ctl;
   logic [3:0][31:0]        px;
   logic [3:0][7:0]         y, cb, cr, out_y;

   assign csr_ready = 1'b1;
   assign ctl.en  = !vld_ff[Depth-1] || !rsp_stall;
   assign ctl.lim = lim_ff;
   assign req_stall = reset || !ctl.en;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         lim_ff  <= 1'b1;
         vld_ff  <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_COEF_LUMA: coef_ff[0] <= csr_data;
               CSR_COEF_CB:   coef_ff[1] <= csr_data;
               CSR_COEF_CR:   coef_ff[2] <= csr_data;
               CSR_LIMITED:   lim_ff     <= csr_data[0];
               default: ;
            endcase
         end
         if (ctl.en)
            vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   assign px = {req_overlay_px3, req_overlay_px2, req_overlay_px1, req_overlay_px0};
   assign side_in.a   = {px[3][31:24], px[2][31:24], px[1][31:24], px[0][31:24]};
   assign side_in.dy  = {req_dest_y3, req_dest_y2, req_dest_y1, req_dest_y0};
   assign side_in.dcb = req_dest_cb;
   assign side_in.dcr = req_dest_cr;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LaneDepth; i++)
            side_ff[i] <= side_ff[i-1];
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      pabl_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .coef  (coef_ff),
         .px    (px[l]),
         .y     (y[l]),
         .cb    (cb[l]),
         .cr    (cr[l])
      );
   end

   pabl_merge u_merge (
      .clock  (clock),
      .ctl    (ctl),
      .y      (y),
      .cb     (cb),
      .cr     (cr),
      .side   (side_ff[LaneDepth-1]),
      .out_y  (out_y),
      .out_cb (rsp_out_cb),
      .out_cr (rsp_out_cr)
   );

   assign rsp_out_y0 = out_y[0];
   assign rsp_out_y1 = out_y[1];
   assign rsp_out_y2 = out_y[2];
   assign rsp_out_y3 = out_y[3];

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_y0) && $stable(rsp_out_cb))
      else $error("result word dropped or changed under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free output");
   a_rst: assert property (@(posedge clock)
      $past(reset) |-> lim_ff && !rsp_valid)
      else $error("reset state wrong");
`endif

endmodule
